// File: rtl/rsns_pkg.sv
// ----------------------------------------------------------------------------
// rsns_pkg
// Shared types and constants for the ring shuttle nearest-request scheduler.
// ----------------------------------------------------------------------------
package rsns_pkg;

    localparam int MASK_W        = 32;   // one bit per station in the masks
    localparam int ST_IDX_W      = 5;    // zero-based station index
    localparam int POS_W         = 9;    // track position
    localparam int TICK_W        = 32;
    localparam int NUM_W         = 6;    // num_stations register and station field
    localparam int GAP_W         = 4;    // station_gap register
    localparam int DEF_MAX_STATIONS = 32;

    localparam logic [NUM_W-1:0] NUM_STATIONS_RST = 6'd5;
    localparam logic [GAP_W-1:0] STATION_GAP_RST  = 4'd3;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_CW_CALL  = 2'd1,
        ACT_CCW_CALL = 2'd2,
        ACT_TARGET   = 2'd3
    } rsns_action_t;

    typedef enum logic {
        DIV_POS_LEN = 1'b0,   // position modulo ring length
        DIV_POS_GAP = 1'b1    // position over station gap
    } rsns_div_op_t;

    typedef enum logic {
        REG_NUM_STATIONS = 1'b0,
        REG_STATION_GAP  = 1'b1
    } rsns_reg_t;

    typedef struct packed {
        logic         req_write;
        logic         div_start;
        rsns_div_op_t div_op;
        logic         load_mod;
        logic         load_search;
        logic         search_step;
        logic         do_move;
        logic         load_out;
        logic         do_stop;
    } rsns_cmd_t;

    typedef struct packed {
        logic div_done;
        logic has_task;
        logic search_done;
        logic out_free;
    } rsns_status_t;

endpackage

// File: rtl/rsns_div.sv
// ----------------------------------------------------------------------------
// rsns_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsns_div
    import rsns_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [POS_W-1:0] divisor,
    output logic             done,
    output logic [POS_W-1:0] quotient,
    output logic [POS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(POS_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(POS_W - 1);

    logic [POS_W-1:0] q_reg, q_next;
    logic [POS_W-1:0] r_reg, r_next;
    logic [POS_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [POS_W:0]   trial;
    logic             ge;

    assign trial = {r_reg, q_reg[POS_W-1]};
    assign ge    = (trial >= {1'b0, d_reg});

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            r_next   = ge ? POS_W'(trial - {1'b0, d_reg}) : trial[POS_W-1:0];
            q_next   = {q_reg[POS_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// File: rtl/rsns_dp.sv
// ----------------------------------------------------------------------------
// rsns_dp
// Scheduler datapath: request masks, shuttle state, search walk, result
// register and the shared divider.
// ----------------------------------------------------------------------------
module rsns_dp
    import rsns_pkg::*;
#(
    parameter int MAX_STATIONS = DEF_MAX_STATIONS
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  rsns_cmd_t         cmd,
    output rsns_status_t      status,
    input  logic [NUM_W-1:0]  cfg_num_stations,
    input  logic [GAP_W-1:0]  cfg_station_gap,
    input  logic [1:0]        in_action,
    input  logic [NUM_W-1:0]  in_station,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [TICK_W-1:0] out_elapsed_ticks,
    output logic [POS_W-1:0]  out_position,
    output logic [MASK_W-1:0] out_target_mask,
    output logic [MASK_W-1:0] out_clockwise_mask,
    output logic [MASK_W-1:0] out_counterclockwise_mask
);

    localparam int CAP = (MAX_STATIONS < MASK_W) ? MAX_STATIONS : MASK_W;
    localparam logic [NUM_W-1:0] CAP_N = NUM_W'(CAP);

    // effective configuration
    logic [NUM_W-1:0] n_eff;
    logic [GAP_W-1:0] gap_eff;
    logic [POS_W-1:0] ring_len;
    logic [ST_IDX_W-1:0] half_n;

    always_comb begin
        n_eff = cfg_num_stations;
        if (n_eff < NUM_W'(2)) n_eff = NUM_W'(2);
        if (n_eff > CAP_N)     n_eff = CAP_N;
    end

    assign gap_eff  = (cfg_station_gap == '0) ? GAP_W'(1) : cfg_station_gap;
    assign ring_len = POS_W'({3'b0, n_eff} * {5'b0, gap_eff});
    assign half_n   = n_eff[NUM_W-1:1];

    // state
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                head_cw_reg, head_cw_next;
    logic                has_task_reg, has_task_next;
    logic                pass_wait_reg, pass_wait_next;
    logic                goal_wait_reg, goal_wait_next;
    logic                goal_valid_reg, goal_valid_next;
    logic [POS_W-1:0]    goal_pos_reg, goal_pos_next;
    logic [MASK_W-1:0]   tgt_reg, tgt_next;
    logic [MASK_W-1:0]   cw_reg, cw_next;
    logic [MASK_W-1:0]   ccw_reg, ccw_next;
    logic [ST_IDX_W-1:0] scw_reg, scw_next;
    logic [ST_IDX_W-1:0] sccw_reg, sccw_next;
    logic [ST_IDX_W-1:0] step_reg, step_next;
    logic                ovalid_reg, ovalid_next;
    logic [TICK_W-1:0]   o_ticks_reg;
    logic [POS_W-1:0]    o_pos_reg;
    logic [MASK_W-1:0]   o_tgt_reg;
    logic [MASK_W-1:0]   o_cw_reg;
    logic [MASK_W-1:0]   o_ccw_reg;

    // divider
    logic             div_done;
    logic [POS_W-1:0] div_quo;
    logic [POS_W-1:0] div_rem;
    logic [POS_W-1:0] div_divisor;

    assign div_divisor = (cmd.div_op == DIV_POS_LEN) ? ring_len : {5'b0, gap_eff};

    rsns_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (pos_reg),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // search helpers
    logic [MASK_W-1:0]   any_mask;
    logic                hit_cw, hit_ccw, search_last;
    logic [POS_W-1:0]    scw_pos, sccw_pos;
    logic [ST_IDX_W-1:0] idx;
    logic [MASK_W-1:0]   keep;
    logic [MASK_W-1:0]   req_bit;
    logic                req_ok;
    logic [MASK_W-1:0]   dir_mask;

    assign any_mask    = tgt_reg | cw_reg | ccw_reg;
    assign hit_cw      = any_mask[scw_reg];
    assign hit_ccw     = any_mask[sccw_reg];
    assign search_last = (step_reg == half_n);
    assign scw_pos     = POS_W'({4'b0, scw_reg} * {5'b0, gap_eff});
    assign sccw_pos    = POS_W'({4'b0, sccw_reg} * {5'b0, gap_eff});
    assign idx         = div_quo[ST_IDX_W-1:0];
    assign keep        = ~(MASK_W'(1) << idx);
    assign req_ok      = (in_station != '0) && (in_station <= n_eff);
    assign req_bit     = MASK_W'(1) << ST_IDX_W'(in_station - NUM_W'(1));
    assign dir_mask    = head_cw_reg ? cw_reg : ccw_reg;

    always_comb begin
        tick_next       = tick_reg;
        pos_next        = pos_reg;
        head_cw_next    = head_cw_reg;
        has_task_next   = has_task_reg;
        pass_wait_next  = pass_wait_reg;
        goal_wait_next  = goal_wait_reg;
        goal_valid_next = goal_valid_reg;
        goal_pos_next   = goal_pos_reg;
        tgt_next        = tgt_reg;
        cw_next         = cw_reg;
        ccw_next        = ccw_reg;
        scw_next        = scw_reg;
        sccw_next       = sccw_reg;
        step_next       = step_reg;
        ovalid_next     = ovalid_reg && !out_ready;

        if (cmd.req_write && req_ok) begin
            case (in_action)
                ACT_CW_CALL:  cw_next  = cw_reg | req_bit;
                ACT_CCW_CALL: ccw_next = ccw_reg | req_bit;
                ACT_TARGET:   tgt_next = tgt_reg | req_bit;
                default:      ;
            endcase
        end

        if (cmd.load_mod) begin
            pos_next  = div_rem;
            tick_next = tick_reg + TICK_W'(1);
        end

        if (cmd.load_search) begin
            scw_next  = idx;
            sccw_next = idx;
            step_next = '0;
        end

        if (cmd.search_step) begin
            if (hit_cw) begin
                has_task_next   = 1'b1;
                goal_valid_next = 1'b1;
                goal_pos_next   = scw_pos;
                head_cw_next    = 1'b1;
            end else if (hit_ccw) begin
                has_task_next   = 1'b1;
                goal_valid_next = 1'b1;
                goal_pos_next   = sccw_pos;
                head_cw_next    = 1'b0;
            end else if (search_last) begin
                has_task_next = 1'b0;
            end else begin
                scw_next  = ({1'b0, scw_reg} + NUM_W'(1) == n_eff) ? '0
                                                                    : scw_reg + ST_IDX_W'(1);
                sccw_next = (sccw_reg == '0) ? ST_IDX_W'(n_eff - NUM_W'(1))
                                             : sccw_reg - ST_IDX_W'(1);
                step_next = step_reg + ST_IDX_W'(1);
            end
        end

        if (cmd.do_move) begin
            if (has_task_reg && !pass_wait_reg && !goal_wait_reg) begin
                if (head_cw_reg) begin
                    pos_next = (pos_reg + POS_W'(1) == ring_len) ? '0 : pos_reg + POS_W'(1);
                end else begin
                    pos_next = (pos_reg == '0) ? ring_len - POS_W'(1) : pos_reg - POS_W'(1);
                end
            end
            pass_wait_next = 1'b0;
            goal_wait_next = 1'b0;
        end

        if (cmd.load_out) begin
            ovalid_next = 1'b1;
        end

        if (cmd.do_stop) begin
            if (goal_valid_reg && pos_reg == goal_pos_reg && any_mask[idx]) begin
                // goal stop: clear every request at this station
                goal_wait_next  = 1'b1;
                tgt_next        = tgt_reg & keep;
                cw_next         = cw_reg & keep;
                ccw_next        = ccw_reg & keep;
                goal_valid_next = 1'b0;
                goal_pos_next   = '0;
                has_task_next   = 1'b0;
            end else if (div_rem == '0 && (tgt_reg[idx] || dir_mask[idx])) begin
                // pass-by stop in the current heading
                pass_wait_next = 1'b1;
                tgt_next       = tgt_reg & keep;
                if (head_cw_reg) begin
                    cw_next = cw_reg & keep;
                end else begin
                    ccw_next = ccw_reg & keep;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        scw_reg  <= scw_next;
        sccw_reg <= sccw_next;
        step_reg <= step_next;
        if (cmd.load_out) begin
            o_ticks_reg <= tick_reg;
            o_pos_reg   <= pos_reg;
            o_tgt_reg   <= tgt_reg;
            o_cw_reg    <= cw_reg;
            o_ccw_reg   <= ccw_reg;
        end
        if (!aresetn) begin
            tick_reg       <= '0;
            pos_reg        <= '0;
            head_cw_reg    <= 1'b1;
            has_task_reg   <= 1'b0;
            pass_wait_reg  <= 1'b0;
            goal_wait_reg  <= 1'b0;
            goal_valid_reg <= 1'b0;
            goal_pos_reg   <= '0;
            tgt_reg        <= '0;
            cw_reg         <= '0;
            ccw_reg        <= '0;
            ovalid_reg     <= 1'b0;
        end else begin
            tick_reg       <= tick_next;
            pos_reg        <= pos_next;
            head_cw_reg    <= head_cw_next;
            has_task_reg   <= has_task_next;
            pass_wait_reg  <= pass_wait_next;
            goal_wait_reg  <= goal_wait_next;
            goal_valid_reg <= goal_valid_next;
            goal_pos_reg   <= goal_pos_next;
            tgt_reg        <= tgt_next;
            cw_reg         <= cw_next;
            ccw_reg        <= ccw_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    assign status.div_done    = div_done;
    assign status.has_task    = has_task_reg;
    assign status.search_done = hit_cw || hit_ccw || search_last;
    assign status.out_free    = !ovalid_reg || out_ready;

    assign out_valid                 = ovalid_reg;
    assign out_elapsed_ticks         = o_ticks_reg;
    assign out_position              = o_pos_reg;
    assign out_target_mask           = o_tgt_reg;
    assign out_clockwise_mask        = o_cw_reg;
    assign out_counterclockwise_mask = o_ccw_reg;

endmodule

// File: rtl/rsns_ctrl.sv
// ----------------------------------------------------------------------------
// rsns_ctrl
// Tick sequencer: reduce, locate, search if no task, move, report, stop.
// ----------------------------------------------------------------------------
module rsns_ctrl
    import rsns_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  logic [1:0]   in_action,
    output logic         in_ready,
    input  rsns_status_t status,
    output rsns_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_RUN,
        ST_QUO_GO,
        ST_QUO_RUN,
        ST_SEARCH,
        ST_MOVE,
        ST_EMIT,
        ST_IDX_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = DIV_POS_GAP;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_action == ACT_TICK) begin
                        cmd.div_start = 1'b1;
                        cmd.div_op    = DIV_POS_LEN;
                        state_next    = ST_MOD_RUN;
                    end else begin
                        cmd.req_write = 1'b1;
                    end
                end
            end
            ST_MOD_RUN: begin
                if (status.div_done) begin
                    cmd.load_mod = 1'b1;
                    state_next   = ST_QUO_GO;
                end
            end
            ST_QUO_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_QUO_RUN;
            end
            ST_QUO_RUN: begin
                if (status.div_done) begin
                    if (status.has_task) begin
                        state_next = ST_MOVE;
                    end else begin
                        cmd.load_search = 1'b1;
                        state_next      = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (status.search_done) begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE: begin
                cmd.do_move = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                // result goes out before the stop check clears any bits
                if (status.out_free) begin
                    cmd.load_out  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_IDX_RUN;
                end
            end
            ST_IDX_RUN: begin
                if (status.div_done) begin
                    cmd.do_stop = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/ring_shuttle_nearest_request_scheduler_unit.sv
// ----------------------------------------------------------------------------
// ring_shuttle_nearest_request_scheduler_unit
// Shuttle scheduler on a ring of stations, nearest request served first.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    s_action, s_station
//   m_        out        m_valid / m_ready    m_elapsed_ticks, m_position, masks
//   apb       in         psel/penable/pready  num_stations (0x0), station_gap (0x4)
//
// a request beat gives no result beat
// a tick makes three passes through the shared 9-step divider, plus a
// one-station-per-cycle walk when the shuttle has no task
// the output register lets a request beat in while a result beat waits;
// the next tick stalls at its report step until the result is taken
// aresetn is synchronous; all but search, divider and result data registers reset
// ----------------------------------------------------------------------------
module ring_shuttle_nearest_request_scheduler_unit
    import rsns_pkg::*;
#(
    parameter int MAX_STATIONS = DEF_MAX_STATIONS
)
(
    input  logic              aclk,
    input  logic              aresetn,
    // input beats
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [NUM_W-1:0]  s_station,
    // result beats
    output logic              m_valid,
    input  logic              m_ready,
    output logic [TICK_W-1:0] m_elapsed_ticks,
    output logic [POS_W-1:0]  m_position,
    output logic [MASK_W-1:0] m_target_mask,
    output logic [MASK_W-1:0] m_clockwise_mask,
    output logic [MASK_W-1:0] m_counterclockwise_mask,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [NUM_W-1:0] num_stations_reg;
    logic [GAP_W-1:0] station_gap_reg;
    logic             cfg_wr;
    rsns_reg_t        reg_sel;

    rsns_cmd_t        cmd;
    rsns_status_t     status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = rsns_reg_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_stations_reg <= NUM_STATIONS_RST;
            station_gap_reg  <= STATION_GAP_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_NUM_STATIONS: num_stations_reg <= pwdata[NUM_W-1:0];
                REG_STATION_GAP:  station_gap_reg  <= pwdata[GAP_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_NUM_STATIONS: prdata = {26'b0, num_stations_reg};
            REG_STATION_GAP:  prdata = {28'b0, station_gap_reg};
            default:          prdata = '0;
        endcase
    end

    rsns_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_action (s_action),
        .in_ready  (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rsns_dp #(
        .MAX_STATIONS (MAX_STATIONS)
    ) u_dp (
        .aclk                      (aclk),
        .aresetn                   (aresetn),
        .cmd                       (cmd),
        .status                    (status),
        .cfg_num_stations          (num_stations_reg),
        .cfg_station_gap           (station_gap_reg),
        .in_action                 (s_action),
        .in_station                (s_station),
        .out_ready                 (m_ready),
        .out_valid                 (m_valid),
        .out_elapsed_ticks         (m_elapsed_ticks),
        .out_position              (m_position),
        .out_target_mask           (m_target_mask),
        .out_clockwise_mask        (m_clockwise_mask),
        .out_counterclockwise_mask (m_counterclockwise_mask)
    );

endmodule
